[sv/vhv_pkg.sv]
`timescale 1ns / 1ps
// vhv_pkg: shared types, field widths and codes for the velocity histogram vote core.
// Has no dependencies; every other file refers to it by scoped names.
package vhv_pkg;

  localparam int VEL_W    = 12;
  localparam int CFG_W    = 5;
  localparam int HIST_W   = 8;
  localparam int SPREAD_W = 12;
  localparam int DEV_W    = 17;
  localparam int SQ_OUT_W = 16;
  localparam int DOM_W    = 6;
  localparam int DROP_W   = 8;

  localparam logic [0:0] CFG_SPEED_MIN = 1'b0;
  localparam logic [0:0] CFG_SPEED_MAX = 1'b1;

  localparam logic [CFG_W-1:0]    SPEED_MIN_RST = 5'd2;
  localparam logic [CFG_W-1:0]    SPEED_MAX_RST = 5'd10;
  localparam logic [HIST_W-1:0]   HIST_SAT      = 8'hFF;
  localparam logic [DROP_W-1:0]   DROP_SAT      = 8'hFF;
  localparam logic [SQ_OUT_W-1:0] SQ_SAT        = 16'hFFFF;

  localparam logic KIND_DEV = 1'b0;
  localparam logic KIND_DOM = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_VOTE     = 6'b000010,
    ST_SCAN     = 6'b000100,
    ST_DEV_GO   = 6'b001000,
    ST_DEV_WAIT = 6'b010000,
    ST_DOM      = 6'b100000
  } state_t;

  // Sweep control from the sequencer to the spread/argmax units.
  typedef struct packed {
    logic clr;
    logic shift;
  } scan_ctl_t;

  // Blob store and deviation unit control.
  typedef struct packed {
    logic wr;
    logic go;
  } dev_ctl_t;

endpackage

[sv/vhv_hist.sv]
`timescale 1ns / 1ps
// vhv_hist: one axis vote histogram, a memory with one read and one write port and per-bin valid bits.
// Does saturating read-modify-write votes and sweep reads. Uses vhv_pkg.
module vhv_hist #(
  parameter int NBINS = 40,
  parameter int BIN_W = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clr,
  input  logic                      vote,
  input  logic [BIN_W-1:0]          vote_bin,
  input  logic                      scan_rd,
  input  logic [BIN_W-1:0]          scan_addr,
  output logic [vhv_pkg::HIST_W-1:0] rd_val
);

  logic [vhv_pkg::HIST_W-1:0] mem [NBINS];
  logic [NBINS-1:0]           valid_r;
  logic [vhv_pkg::HIST_W-1:0] rd_q_r;
  logic                       rd_v_r;
  logic                       pend_r;
  logic [BIN_W-1:0]           pend_bin_r;
  logic [BIN_W-1:0]           rd_addr;
  logic [vhv_pkg::HIST_W-1:0] inc_val;

  assign rd_addr = vote ? vote_bin : scan_addr;
  // A bin never written since the last clear reads as zero.
  assign rd_val  = rd_v_r ? rd_q_r : '0;
  assign inc_val = (rd_val == vhv_pkg::HIST_SAT) ? rd_val : rd_val + 1'b1;

  always_ff @(posedge clk) begin
    if (vote || scan_rd) begin
      rd_q_r <= mem[rd_addr];
      rd_v_r <= valid_r[rd_addr];
    end
    if (pend_r) begin
      mem[pend_bin_r] <= inc_val;
    end
    pend_bin_r <= vote_bin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= '0;
    end else if (pend_r) begin
      valid_r[pend_bin_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= vote;
    end
  end

endmodule

[sv/vhv_spread.sv]
`timescale 1ns / 1ps
// vhv_spread: sliding 1-2-3-2-1 spread over a streamed histogram and first-max search.
// Takes one bin per cycle from vhv_hist; uses vhv_pkg.
module vhv_spread #(
  parameter int MAX_SPEED = 20,
  parameter int NBINS     = 40,
  parameter int BIN_W     = 6,
  parameter int SCN_W     = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  vhv_pkg::scan_ctl_t         ctl,
  input  logic [vhv_pkg::CFG_W-1:0]  speed_min,
  input  logic [vhv_pkg::CFG_W-1:0]  speed_max,
  input  logic [vhv_pkg::HIST_W-1:0] rd_val,
  output logic signed [BIN_W-1:0]    dom
);

  logic [SCN_W-1:0]              in_cnt_r;
  logic                          ctr_vld_r;
  logic [SCN_W-1:0]              ctr_idx_r;
  logic [vhv_pkg::HIST_W-1:0]    win_g_r [5];
  logic [vhv_pkg::HIST_W-1:0]    win_p_r [3];
  logic [vhv_pkg::SPREAD_W-1:0]  best_r;
  logic [BIN_W-1:0]              best_idx_r;
  logic                          in_ok;
  logic                          in_bd;
  logic                          in_zero;
  logic                          ctr_bd;
  logic [vhv_pkg::HIST_W-1:0]    g_in;
  logic [vhv_pkg::HIST_W-1:0]    p_in;
  logic [vhv_pkg::SPREAD_W-1:0]  sp;

  function automatic logic in_band(int i, int mn, int mx);
    return ((i <= MAX_SPEED - mn) && (i >= MAX_SPEED - mx)) ||
           ((i >= MAX_SPEED + mn) && (i <= MAX_SPEED + mx));
  endfunction

  always_comb begin
    in_ok   = in_cnt_r < SCN_W'(NBINS);
    in_bd   = in_band(int'(in_cnt_r), int'(speed_min), int'(speed_max));
    in_zero = in_cnt_r == SCN_W'(MAX_SPEED);
    // In-band bins spread, other bins pass; the zero bin only receives.
    g_in    = (in_ok && in_bd && !in_zero) ? rd_val : '0;
    p_in    = (in_ok && !in_bd && !in_zero) ? rd_val : '0;
    ctr_bd  = in_band(int'(ctr_idx_r), int'(speed_min), int'(speed_max));
    // Peak is 9 * 255, so the sum never reaches the 12-bit ceiling.
    sp = vhv_pkg::SPREAD_W'(win_g_r[0]) +
         vhv_pkg::SPREAD_W'({win_g_r[1], 1'b0}) +
         vhv_pkg::SPREAD_W'(win_g_r[2]) +
         vhv_pkg::SPREAD_W'({win_g_r[2], 1'b0}) +
         vhv_pkg::SPREAD_W'({win_g_r[3], 1'b0}) +
         vhv_pkg::SPREAD_W'(win_g_r[4]) +
         vhv_pkg::SPREAD_W'(win_p_r[2]);
    dom = (best_r != '0) ? BIN_W'(int'(best_idx_r) - MAX_SPEED) : '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      for (int i = 0; i < 5; i++) begin
        win_g_r[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        win_p_r[i] <= '0;
      end
      best_r     <= '0;
      best_idx_r <= '0;
    end else begin
      if (ctl.shift) begin
        win_g_r[0] <= g_in;
        win_p_r[0] <= p_in;
        for (int i = 1; i < 5; i++) begin
          win_g_r[i] <= win_g_r[i-1];
        end
        for (int i = 1; i < 3; i++) begin
          win_p_r[i] <= win_p_r[i-1];
        end
      end
      // Strict compare keeps the first of equal peaks.
      if (ctr_vld_r && ctr_bd && (sp > best_r)) begin
        best_r     <= sp;
        best_idx_r <= ctr_idx_r[BIN_W-1:0];
      end
    end
    if (ctl.shift) begin
      ctr_idx_r <= in_cnt_r - SCN_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      in_cnt_r  <= '0;
      ctr_vld_r <= 1'b0;
    end else if (ctl.shift) begin
      in_cnt_r  <= in_cnt_r + SCN_W'(1);
      ctr_vld_r <= in_cnt_r >= SCN_W'(2);
    end else begin
      ctr_vld_r <= 1'b0;
    end
  end

endmodule

[sv/vhv_dev.sv]
`timescale 1ns / 1ps
// vhv_dev: blob velocity store and squared-deviation unit around one shared multiplier.
// Uses vhv_pkg; driven by the sequencer in the top level.
module vhv_dev #(
  parameter int MAX_BLOBS = 63,
  parameter int IDX_W     = 6,
  parameter int FRAC_BITS = 4,
  parameter int DOMW      = 6
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  vhv_pkg::dev_ctl_t                ctl,
  input  logic [IDX_W-1:0]                 wr_idx,
  input  logic signed [vhv_pkg::VEL_W-1:0] wr_vel_x,
  input  logic signed [vhv_pkg::VEL_W-1:0] wr_vel_y,
  input  logic [IDX_W-1:0]                 rd_idx,
  input  logic signed [DOMW-1:0]           dom_x,
  input  logic signed [DOMW-1:0]           dom_y,
  input  logic [vhv_pkg::CFG_W-1:0]        speed_min,
  input  logic [vhv_pkg::CFG_W-1:0]        speed_max,
  output logic                             done,
  output logic [vhv_pkg::DEV_W-1:0]        dev
);

  localparam int EXW   = ((vhv_pkg::VEL_W > DOMW + FRAC_BITS) ?
                          vhv_pkg::VEL_W : DOMW + FRAC_BITS) + 1;
  localparam int CMP_W = ((vhv_pkg::VEL_W > vhv_pkg::CFG_W + FRAC_BITS + 1) ?
                          vhv_pkg::VEL_W : vhv_pkg::CFG_W + FRAC_BITS + 1) + 1;
  localparam int SQ_W  = 2 * EXW - 1;
  localparam int SUM_W = 2 * EXW;

  logic signed [vhv_pkg::VEL_W-1:0] mem_x [MAX_BLOBS];
  logic signed [vhv_pkg::VEL_W-1:0] mem_y [MAX_BLOBS];
  logic signed [vhv_pkg::VEL_W-1:0] sx_r;
  logic signed [vhv_pkg::VEL_W-1:0] sy_r;
  logic signed [EXW-1:0]            ex_r;
  logic signed [EXW-1:0]            ey_r;
  logic signed [EXW-1:0]            ex;
  logic signed [EXW-1:0]            ey;
  logic signed [EXW-1:0]            mul_a;
  logic signed [2*EXW-1:0]          mul_p;
  logic [SQ_W-1:0]                  prod_r;
  logic [SQ_W-1:0]                  acc_r;
  logic                             band_r;
  logic                             band;
  logic [3:0]                       stg_r;
  logic signed [CMP_W-1:0]          sx_c;
  logic signed [CMP_W-1:0]          mn_fx;
  logic signed [CMP_W-1:0]          mx_fx;
  logic [SUM_W-1:0]                 sum;
  logic [SUM_W-1:0]                 sum_sh;

  always_comb begin
    sx_c   = CMP_W'(sx_r);
    mn_fx  = $signed(CMP_W'(speed_min)) <<< FRAC_BITS;
    mx_fx  = $signed(CMP_W'(speed_max)) <<< FRAC_BITS;
    band   = ((sx_c <= -mn_fx) && (sx_c >= -mx_fx)) ||
             ((sx_c >= mn_fx) && (sx_c <= mx_fx));
    ex     = EXW'(sx_r) - (EXW'(dom_x) <<< FRAC_BITS);
    ey     = EXW'(sy_r) - (EXW'(dom_y) <<< FRAC_BITS);
    // Square x first, then y, on the same multiplier.
    mul_a  = stg_r[2] ? ey_r : ex_r;
    mul_p  = mul_a * mul_a;
    sum    = SUM_W'(acc_r) + SUM_W'(prod_r);
    sum_sh = sum >> (2 * FRAC_BITS);
    done   = stg_r[3];
    if (!band_r) begin
      dev = '1;
    end else if (sum_sh > SUM_W'(vhv_pkg::SQ_SAT)) begin
      dev = {1'b0, vhv_pkg::SQ_SAT};
    end else begin
      dev = {1'b0, sum_sh[vhv_pkg::SQ_OUT_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem_x[wr_idx] <= wr_vel_x;
      mem_y[wr_idx] <= wr_vel_y;
    end
    if (ctl.go) begin
      sx_r <= mem_x[rd_idx];
      sy_r <= mem_y[rd_idx];
    end
    if (stg_r[0]) begin
      ex_r   <= ex;
      ey_r   <= ey;
      band_r <= band;
    end
    if (stg_r[1] || stg_r[2]) begin
      prod_r <= SQ_W'(mul_p);
    end
    if (stg_r[2]) begin
      acc_r <= prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= '0;
    end else begin
      stg_r <= {stg_r[2:0], ctl.go};
    end
  end

endmodule

[sv/velocity_histogram_vote_core.sv]
`timescale 1ns / 1ps
// velocity_histogram_vote_core: top level, sequencer, config registers and result register.
// Instantiates vhv_hist, vhv_spread and vhv_dev; uses vhv_pkg.
//
// After an item is taken, busy is high in ST_VOTE while the vote is written back to the
// histogram bin. An item with in_frame_end then sweeps both histograms, one bin per
// cycle, through the spread and peak search. Each stored blob of the frame then passes
// through the deviation unit, whose one multiplier squares x and then y. The dominant
// result follows in the cycle after the last deviation. Each result sits on the out_
// ports for exactly one cycle with out_strobe high; there is no way to stall it, so the
// receiver must take every strobe. The histograms clear in ST_DOM at the end of each
// frame. Write speed_min and speed_max only while busy is low; cfg_ready is always high.
module velocity_histogram_vote_core #(
  parameter int MAX_SPEED = 20,
  parameter int MAX_BLOBS = 63,
  parameter int FRAC_BITS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [vhv_pkg::VEL_W-1:0]  in_vel_x,
  input  logic signed [vhv_pkg::VEL_W-1:0]  in_vel_y,
  input  logic                              in_has_blob,
  input  logic                              in_frame_end,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [0:0]                        cfg_index,
  input  logic [vhv_pkg::CFG_W-1:0]         cfg_data,
  output logic                              out_strobe,
  output logic                              out_kind,
  output logic signed [vhv_pkg::DEV_W-1:0]  out_deviation,
  output logic signed [vhv_pkg::DOM_W-1:0]  out_dominant_x,
  output logic signed [vhv_pkg::DOM_W-1:0]  out_dominant_y,
  output logic [vhv_pkg::DROP_W-1:0]        out_dropped,
  output logic                              out_last
);

  localparam int NBINS = 2 * MAX_SPEED;
  localparam int BIN_W = $clog2(NBINS);
  localparam int SCN_W = $clog2(NBINS + 4);
  localparam int CNT_W = $clog2(MAX_BLOBS + 1);
  localparam int IDX_W = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
  localparam int VW    = ((vhv_pkg::VEL_W > $clog2(MAX_SPEED) + FRAC_BITS + 1) ?
                          vhv_pkg::VEL_W : $clog2(MAX_SPEED) + FRAC_BITS + 1) + 1;
  localparam logic signed [VW-1:0] LIM = VW'(MAX_SPEED << FRAC_BITS);

  vhv_pkg::state_t              state_r, state_nxt;
  logic                         fe_r, fe_nxt;
  logic [SCN_W-1:0]             s_r, s_nxt;
  logic [CNT_W-1:0]             k_r, k_nxt;
  logic [CNT_W-1:0]             blob_count_r, blob_count_nxt;
  logic [vhv_pkg::DROP_W-1:0]   dropped_r, dropped_nxt;
  logic [vhv_pkg::CFG_W-1:0]    speed_min_r, speed_max_r;
  logic                         shift_r;
  logic                         strobe_r, strobe_nxt;
  logic                         kind_r, kind_nxt;
  logic [vhv_pkg::DEV_W-1:0]    dev_out_r, dev_out_nxt;
  logic [vhv_pkg::DOM_W-1:0]    domx_out_r, domx_out_nxt;
  logic [vhv_pkg::DOM_W-1:0]    domy_out_r, domy_out_nxt;
  logic [vhv_pkg::DROP_W-1:0]   drop_out_r, drop_out_nxt;
  logic                         last_r, last_nxt;

  logic                         accept;
  logic signed [VW-1:0]         vx_e, vy_e, off_x, off_y;
  logic                         x_in, y_in, vote;
  logic [BIN_W-1:0]             bin_x, bin_y;
  logic                         scan_rd, hist_clr;
  logic [BIN_W-1:0]             scan_addr;
  logic [vhv_pkg::HIST_W-1:0]   rd_x, rd_y;
  vhv_pkg::scan_ctl_t           scan_ctl;
  vhv_pkg::dev_ctl_t            dev_ctl;
  logic signed [BIN_W-1:0]      dom_x, dom_y;
  logic                         dev_done;
  logic [vhv_pkg::DEV_W-1:0]    dev_val;
  logic                         store_ok;

  assign busy      = (state_r != vhv_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Bin = floor(v) + R, only when both axes sit inside [-R, R).
  always_comb begin
    vx_e  = VW'(in_vel_x);
    vy_e  = VW'(in_vel_y);
    x_in  = (vx_e >= -LIM) && (vx_e < LIM);
    y_in  = (vy_e >= -LIM) && (vy_e < LIM);
    off_x = vx_e + LIM;
    off_y = vy_e + LIM;
    bin_x = BIN_W'(off_x >>> FRAC_BITS);
    bin_y = BIN_W'(off_y >>> FRAC_BITS);
    vote  = accept && in_has_blob && x_in && y_in;
  end

  assign store_ok       = blob_count_r < CNT_W'(MAX_BLOBS);
  assign dev_ctl.wr     = accept && in_has_blob && store_ok;
  assign dev_ctl.go     = (state_r == vhv_pkg::ST_DEV_GO);
  assign scan_rd        = (state_r == vhv_pkg::ST_SCAN) && (s_r < SCN_W'(NBINS));
  assign scan_addr      = s_r[BIN_W-1:0];
  assign scan_ctl.clr   = (state_r == vhv_pkg::ST_SCAN) && (s_r == '0);
  assign scan_ctl.shift = shift_r;
  assign hist_clr       = (state_r == vhv_pkg::ST_DOM);

  vhv_hist #(.NBINS(NBINS), .BIN_W(BIN_W)) u_hist_x (
    .clk(clk), .rst_n(rst_n), .clr(hist_clr), .vote(vote), .vote_bin(bin_x),
    .scan_rd(scan_rd), .scan_addr(scan_addr), .rd_val(rd_x)
  );

  vhv_hist #(.NBINS(NBINS), .BIN_W(BIN_W)) u_hist_y (
    .clk(clk), .rst_n(rst_n), .clr(hist_clr), .vote(vote), .vote_bin(bin_y),
    .scan_rd(scan_rd), .scan_addr(scan_addr), .rd_val(rd_y)
  );

  vhv_spread #(.MAX_SPEED(MAX_SPEED), .NBINS(NBINS), .BIN_W(BIN_W), .SCN_W(SCN_W)) u_spread_x (
    .clk(clk), .rst_n(rst_n), .ctl(scan_ctl), .speed_min(speed_min_r),
    .speed_max(speed_max_r), .rd_val(rd_x), .dom(dom_x)
  );

  vhv_spread #(.MAX_SPEED(MAX_SPEED), .NBINS(NBINS), .BIN_W(BIN_W), .SCN_W(SCN_W)) u_spread_y (
    .clk(clk), .rst_n(rst_n), .ctl(scan_ctl), .speed_min(speed_min_r),
    .speed_max(speed_max_r), .rd_val(rd_y), .dom(dom_y)
  );

  vhv_dev #(
    .MAX_BLOBS(MAX_BLOBS), .IDX_W(IDX_W), .FRAC_BITS(FRAC_BITS), .DOMW(BIN_W)
  ) u_dev (
    .clk(clk), .rst_n(rst_n), .ctl(dev_ctl),
    .wr_idx(blob_count_r[IDX_W-1:0]), .wr_vel_x(in_vel_x), .wr_vel_y(in_vel_y),
    .rd_idx(k_r[IDX_W-1:0]), .dom_x(dom_x), .dom_y(dom_y),
    .speed_min(speed_min_r), .speed_max(speed_max_r),
    .done(dev_done), .dev(dev_val)
  );

  always_comb begin
    state_nxt      = state_r;
    fe_nxt         = fe_r;
    s_nxt          = s_r;
    k_nxt          = k_r;
    blob_count_nxt = blob_count_r;
    dropped_nxt    = dropped_r;
    strobe_nxt     = 1'b0;
    kind_nxt       = kind_r;
    dev_out_nxt    = dev_out_r;
    domx_out_nxt   = domx_out_r;
    domy_out_nxt   = domy_out_r;
    drop_out_nxt   = drop_out_r;
    last_nxt       = last_r;
    case (state_r)
      vhv_pkg::ST_IDLE: begin
        if (accept) begin
          fe_nxt = in_frame_end;
          if (in_has_blob) begin
            if (store_ok) begin
              blob_count_nxt = blob_count_r + CNT_W'(1);
            end else if (dropped_r != vhv_pkg::DROP_SAT) begin
              dropped_nxt = dropped_r + 1'b1;
            end
          end
          state_nxt = vhv_pkg::ST_VOTE;
        end
      end
      vhv_pkg::ST_VOTE: begin
        // Vote write-back lands at the end of this cycle.
        s_nxt     = '0;
        state_nxt = fe_r ? vhv_pkg::ST_SCAN : vhv_pkg::ST_IDLE;
      end
      vhv_pkg::ST_SCAN: begin
        s_nxt = s_r + SCN_W'(1);
        if (s_r == SCN_W'(NBINS + 3)) begin
          k_nxt     = '0;
          state_nxt = (blob_count_r == '0) ? vhv_pkg::ST_DOM : vhv_pkg::ST_DEV_GO;
        end
      end
      vhv_pkg::ST_DEV_GO: begin
        state_nxt = vhv_pkg::ST_DEV_WAIT;
      end
      vhv_pkg::ST_DEV_WAIT: begin
        if (dev_done) begin
          strobe_nxt   = 1'b1;
          kind_nxt     = vhv_pkg::KIND_DEV;
          dev_out_nxt  = dev_val;
          domx_out_nxt = vhv_pkg::DOM_W'(int'(dom_x));
          domy_out_nxt = vhv_pkg::DOM_W'(int'(dom_y));
          drop_out_nxt = dropped_r;
          last_nxt     = 1'b0;
          k_nxt        = k_r + CNT_W'(1);
          state_nxt    = (k_r + CNT_W'(1) == blob_count_r) ?
                         vhv_pkg::ST_DOM : vhv_pkg::ST_DEV_GO;
        end
      end
      vhv_pkg::ST_DOM: begin
        strobe_nxt     = 1'b1;
        kind_nxt       = vhv_pkg::KIND_DOM;
        dev_out_nxt    = '0;
        domx_out_nxt   = vhv_pkg::DOM_W'(int'(dom_x));
        domy_out_nxt   = vhv_pkg::DOM_W'(int'(dom_y));
        drop_out_nxt   = dropped_r;
        last_nxt       = 1'b1;
        blob_count_nxt = '0;
        dropped_nxt    = '0;
        state_nxt      = vhv_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = vhv_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= vhv_pkg::ST_IDLE;
      fe_r         <= 1'b0;
      s_r          <= '0;
      k_r          <= '0;
      blob_count_r <= '0;
      dropped_r    <= '0;
      shift_r      <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fe_r         <= fe_nxt;
      s_r          <= s_nxt;
      k_r          <= k_nxt;
      blob_count_r <= blob_count_nxt;
      dropped_r    <= dropped_nxt;
      shift_r      <= (state_r == vhv_pkg::ST_SCAN) && (s_r < SCN_W'(NBINS + 2));
      strobe_r     <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_min_r <= vhv_pkg::SPEED_MIN_RST;
      speed_max_r <= vhv_pkg::SPEED_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vhv_pkg::CFG_SPEED_MIN: speed_min_r <= cfg_data;
        vhv_pkg::CFG_SPEED_MAX: speed_max_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    dev_out_r  <= dev_out_nxt;
    domx_out_r <= domx_out_nxt;
    domy_out_r <= domy_out_nxt;
    drop_out_r <= drop_out_nxt;
    last_r     <= last_nxt;
  end

  assign out_strobe     = strobe_r;
  assign out_kind       = kind_r;
  assign out_deviation  = dev_out_r;
  assign out_dominant_x = domx_out_r;
  assign out_dominant_y = domy_out_r;
  assign out_dropped    = drop_out_r;
  assign out_last       = last_r;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for velocity_histogram_vote_core, with an in-bench histogram predictor.
// Drives velocity requests and speed-band writes at the falling edge, checks results at the
// rising edge. Depends on vhv_pkg and the core RTL only.
module tb;

  localparam int SPEED_R        = 20;
  localparam int BINS           = 2 * SPEED_R;
  localparam int STORE_DEPTH    = 63;
  localparam int FRAC           = 4;
  localparam int LIM            = SPEED_R << FRAC;
  localparam int SETTLE         = 100;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int PHASE_REQUESTS = 10;
  localparam int N_DIRECTED     = 19;

  typedef int bin_row_t [BINS];

  typedef struct packed {
    logic signed [vhv_pkg::VEL_W-1:0] vel_x;
    logic signed [vhv_pkg::VEL_W-1:0] vel_y;
    logic                             has_blob;
    logic                             frame_end;
  } blob_req_t;

  typedef struct packed {
    logic                              kind;
    logic signed [vhv_pkg::DEV_W-1:0]  deviation;
    logic signed [vhv_pkg::DOM_W-1:0]  dominant_x;
    logic signed [vhv_pkg::DOM_W-1:0]  dominant_y;
    logic [vhv_pkg::DROP_W-1:0]        dropped;
    logic                              last;
  } motion_result_t;

  typedef struct {
    int vel_x;
    int vel_y;
    bit has_blob;
    bit frame_end;
    int reps;
    bit typed;
    int t_dx;
    int t_dy;
    int t_drop;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [vhv_pkg::VEL_W-1:0] in_vel_x;
  logic signed [vhv_pkg::VEL_W-1:0] in_vel_y;
  logic in_has_blob;
  logic in_frame_end;
  logic cfg_valid;
  logic cfg_ready;
  logic [0:0] cfg_index;
  logic [vhv_pkg::CFG_W-1:0] cfg_data;
  logic out_strobe;
  logic out_kind;
  logic signed [vhv_pkg::DEV_W-1:0] out_deviation;
  logic signed [vhv_pkg::DOM_W-1:0] out_dominant_x;
  logic signed [vhv_pkg::DOM_W-1:0] out_dominant_y;
  logic [vhv_pkg::DROP_W-1:0] out_dropped;
  logic out_last;

  // Predictor copy of the block state and speed band.
  int speed_lo;
  int speed_hi;
  bin_row_t votes_x;
  bin_row_t votes_y;
  int kept_x [STORE_DEPTH];
  int kept_y [STORE_DEPTH];
  int kept_count;
  int drop_count;

  motion_result_t due_results [$];
  motion_result_t head_result;
  int fail_count;
  int idle_pct;

  // Typed dominant values only where they are obvious; the rest comes from the predictor.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{0, 0, 1'b0, 1'b1, 1, 1'b1, 0, 0, 0},
    '{-2048, 2047, 1'b1, 1'b0, 1, 1'b0, 0, 0, 0},
    '{2047, -2048, 1'b1, 1'b1, 1, 1'b1, 0, 0, 0},
    '{1365, -1366, 1'b0, 1'b0, 1, 1'b0, 0, 0, 0},
    '{48, -48, 1'b1, 1'b1, 1, 1'b1, 3, -3, 0},
    '{0, 0, 1'b1, 1'b0, 3, 1'b0, 0, 0, 0},
    '{0, 0, 1'b0, 1'b1, 1, 1'b1, 0, 0, 0},
    '{-128, 0, 1'b1, 1'b0, 1, 1'b0, 0, 0, 0},
    '{128, 0, 1'b1, 1'b1, 1, 1'b1, -8, 0, 0},
    '{-1, -17, 1'b1, 1'b0, 1, 1'b0, 0, 0, 0},
    '{-320, 319, 1'b1, 1'b0, 1, 1'b0, 0, 0, 0},
    '{320, -321, 1'b1, 1'b0, 1, 1'b0, 0, 0, 0},
    '{17, 1, 1'b1, 1'b1, 1, 1'b0, 0, 0, 0},
    '{100, -100, 1'b1, 1'b0, 64, 1'b0, 0, 0, 0},
    '{100, -100, 1'b1, 1'b1, 1, 1'b1, 6, -7, 2},
    '{160, 32, 1'b1, 1'b0, 1, 1'b0, 0, 0, 0},
    '{-32, -160, 1'b1, 1'b0, 1, 1'b0, 0, 0, 0},
    '{31, 161, 1'b1, 1'b0, 1, 1'b0, 0, 0, 0},
    '{-161, 0, 1'b1, 1'b1, 1, 1'b0, 0, 0, 0}
  };

  velocity_histogram_vote_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_vel_x       (in_vel_x),
    .in_vel_y       (in_vel_y),
    .in_has_blob    (in_has_blob),
    .in_frame_end   (in_frame_end),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_strobe     (out_strobe),
    .out_kind       (out_kind),
    .out_deviation  (out_deviation),
    .out_dominant_x (out_dominant_x),
    .out_dominant_y (out_dominant_y),
    .out_dropped    (out_dropped),
    .out_last       (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #(5_000_000);
    $display("status: fail");
    $finish;
  end

  function automatic bit speed_band_bin(int i);
    return (i <= SPEED_R - speed_lo && i >= SPEED_R - speed_hi) ||
           (i >= SPEED_R + speed_lo && i <= SPEED_R + speed_hi);
  endfunction

  // Spread in-band bins by 1,2,3,2,1; the zero bin passes nothing of its own.
  function automatic void spread_votes(input bin_row_t votes, output bin_row_t sp);
    int weight [5];
    int t;
    weight = '{1, 2, 3, 2, 1};
    for (int i = 0; i < BINS; i++) sp[i] = 0;
    for (int i = 0; i < BINS; i++) begin
      if (i == SPEED_R) continue;
      if (speed_band_bin(i)) begin
        for (int j = 0; j < 5; j++) begin
          t = i + j - 2;
          if (t >= 0 && t < BINS) sp[t] = (sp[t] + weight[j] * votes[i] > 4095) ? 4095 :
                                          sp[t] + weight[j] * votes[i];
        end
      end else begin
        sp[i] = (sp[i] + votes[i] > 4095) ? 4095 : sp[i] + votes[i];
      end
    end
  endfunction

  // First strictly largest in-band bin, as an offset from zero velocity.
  function automatic int peak_offset(input bin_row_t sp);
    int best;
    int idx;
    best = 0;
    idx = 0;
    for (int i = 0; i < BINS; i++) begin
      if (speed_band_bin(i) && sp[i] > best) begin
        best = sp[i];
        idx = i;
      end
    end
    return (best > 0) ? idx - SPEED_R : 0;
  endfunction

  // Append one expected result at the tail of the queue.
  task automatic queue_result(input motion_result_t res);
    due_results.insert(due_results.size(), res);
  endtask

  task automatic vote_and_rank(input blob_req_t req);
    int vx;
    int vy;
    int dx;
    int dy;
    int mn;
    int mx;
    longint ex;
    longint ey;
    longint sq;
    bin_row_t sp_x;
    bin_row_t sp_y;
    motion_result_t res;
    vx = req.vel_x;
    vy = req.vel_y;
    if (req.has_blob) begin
      if (vx >= -LIM && vx < LIM && vy >= -LIM && vy < LIM) begin
        if (votes_x[(vx + LIM) >> FRAC] < 255) votes_x[(vx + LIM) >> FRAC]++;
        if (votes_y[(vy + LIM) >> FRAC] < 255) votes_y[(vy + LIM) >> FRAC]++;
      end
      if (kept_count < STORE_DEPTH) begin
        kept_x[kept_count] = vx;
        kept_y[kept_count] = vy;
        kept_count++;
      end else if (drop_count < 255) begin
        drop_count++;
      end
    end
    if (!req.frame_end) return;
    spread_votes(votes_x, sp_x);
    spread_votes(votes_y, sp_y);
    dx = peak_offset(sp_x);
    dy = peak_offset(sp_y);
    mn = speed_lo << FRAC;
    mx = speed_hi << FRAC;
    res.dominant_x = vhv_pkg::DOM_W'(dx);
    res.dominant_y = vhv_pkg::DOM_W'(dy);
    res.dropped    = vhv_pkg::DROP_W'(drop_count);
    for (int k = 0; k < kept_count; k++) begin
      res.kind = vhv_pkg::KIND_DEV;
      res.last = 1'b0;
      if ((kept_x[k] <= -mn && kept_x[k] >= -mx) || (kept_x[k] >= mn && kept_x[k] <= mx)) begin
        ex = kept_x[k] - dx * (1 << FRAC);
        ey = kept_y[k] - dy * (1 << FRAC);
        sq = (ex * ex + ey * ey) >> (2 * FRAC);
        if (sq > 65535) sq = 65535;
        res.deviation = vhv_pkg::DEV_W'(sq);
      end else begin
        res.deviation = '1;
      end
      queue_result(res);
    end
    res.kind = vhv_pkg::KIND_DOM;
    res.deviation = '0;
    res.last = 1'b1;
    queue_result(res);
    for (int i = 0; i < BINS; i++) begin
      votes_x[i] = 0;
      votes_y[i] = 0;
    end
    kept_count = 0;
    drop_count = 0;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (due_results.size() == 0) begin
        $error("result with no request pending: kind %0d deviation %0d", out_kind,
               out_deviation);
        fail_count++;
      end else begin
        head_result = due_results.pop_front();
        check_field("kind", head_result.kind, out_kind);
        check_field("deviation", head_result.deviation, out_deviation);
        check_field("dominant_x", head_result.dominant_x, out_dominant_x);
        check_field("dominant_y", head_result.dominant_y, out_dominant_y);
        check_field("dropped", head_result.dropped, out_dropped);
        check_field("last", head_result.last, out_last);
      end
    end
  end

  // Present one request and hold it until the block takes it.
  task automatic send_request(input blob_req_t req);
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_vel_x     = req.vel_x;
    in_vel_y     = req.vel_y;
    in_has_blob  = req.has_blob;
    in_frame_end = req.frame_end;
    start        = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    vote_and_rank(req);
  endtask

  task automatic write_speed(input logic [0:0] idx, input int value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = vhv_pkg::CFG_W'(value);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == vhv_pkg::CFG_SPEED_MIN) speed_lo = value;
    else speed_hi = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold off band writes until the last frame is fully out and the block is quiet.
  task automatic drain_and_settle();
    @(negedge clk);
    start = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy !== 1'b0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Frames of blobs clustered around one velocity, with some wild values and empty requests.
  task automatic run_random_frames(input int budget);
    int counted;
    int n;
    int cx;
    int cy;
    blob_req_t req;
    counted = 0;
    while (counted < budget) begin
      n  = int'($urandom_range(0, 6));
      cx = int'($urandom_range(0, BINS - 1)) - SPEED_R;
      cy = int'($urandom_range(0, BINS - 1)) - SPEED_R;
      for (int k = 0; k <= n; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          req.vel_x     = vhv_pkg::VEL_W'($urandom);
          req.vel_y     = vhv_pkg::VEL_W'($urandom);
          req.has_blob  = 1'b0;
          req.frame_end = 1'b0;
          send_request(req);
        end
        if ($urandom_range(0, 5) == 0) begin
          req.vel_x = vhv_pkg::VEL_W'($urandom);
          req.vel_y = vhv_pkg::VEL_W'($urandom);
        end else begin
          req.vel_x = vhv_pkg::VEL_W'(cx * 16 + int'($urandom_range(0, 63)) - 32);
          req.vel_y = vhv_pkg::VEL_W'(cy * 16 + int'($urandom_range(0, 63)) - 32);
        end
        req.has_blob  = (k < n) || ($urandom_range(0, 3) != 0);
        req.frame_end = (k == n);
        send_request(req);
        counted++;
      end
    end
  endtask

  initial begin
    blob_req_t req;
    motion_result_t typed_result;
    int lo;
    int hi;
    int wait_cycles;
    start        = 1'b0;
    rst_n        = 1'b0;
    in_vel_x     = '0;
    in_vel_y     = '0;
    in_has_blob  = 1'b0;
    in_frame_end = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = vhv_pkg::CFG_SPEED_MIN;
    cfg_data     = '0;
    fail_count   = 0;
    idle_pct     = 20;
    speed_lo     = int'(vhv_pkg::SPEED_MIN_RST);
    speed_hi     = int'(vhv_pkg::SPEED_MAX_RST);
    for (int i = 0; i < BINS; i++) begin
      votes_x[i] = 0;
      votes_y[i] = 0;
    end
    kept_count = 0;
    drop_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < N_DIRECTED; r++) begin
      repeat (directed_rows[r].reps) begin
        req.vel_x     = vhv_pkg::VEL_W'(directed_rows[r].vel_x);
        req.vel_y     = vhv_pkg::VEL_W'(directed_rows[r].vel_y);
        req.has_blob  = directed_rows[r].has_blob;
        req.frame_end = directed_rows[r].frame_end;
        send_request(req);
        if (directed_rows[r].typed) begin
          typed_result            = due_results.pop_back();
          typed_result.dominant_x = vhv_pkg::DOM_W'(directed_rows[r].t_dx);
          typed_result.dominant_y = vhv_pkg::DOM_W'(directed_rows[r].t_dy);
          typed_result.dropped    = vhv_pkg::DROP_W'(directed_rows[r].t_drop);
          queue_result(typed_result);
        end
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      drain_and_settle();
      case (phase)
        0: begin
          lo = 0;
          hi = 20;
          idle_pct = 20;
        end
        1: begin
          lo = 20;
          hi = 20;
          idle_pct = 85;
        end
        2: begin
          lo = int'($urandom_range(0, 10));
          hi = int'($urandom_range(lo, 20));
          idle_pct = 0;
        end
        default: begin
          lo = int'($urandom_range(0, 20));
          hi = int'($urandom_range(0, 20));
          idle_pct = 0;
        end
      endcase
      write_speed(vhv_pkg::CFG_SPEED_MIN, lo);
      write_speed(vhv_pkg::CFG_SPEED_MAX, hi);
      run_random_frames(PHASE_REQUESTS);
    end

    @(negedge clk);
    start = 1'b0;
    for (wait_cycles = 0; wait_cycles < DRAIN_LIMIT && due_results.size() != 0; wait_cycles++)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("%0d expected results never arrived", due_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[velocity_histogram_vote_core.f]
sv/vhv_pkg.sv
sv/vhv_hist.sv
sv/vhv_spread.sv
sv/vhv_dev.sv
sv/velocity_histogram_vote_core.sv
tb/tb.sv
